[design/obef_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obef_pkg: shared definitions for the oriented box extent finder
// Field widths, default parameter values and the stage control bundle.
// ----------------------------------------------------------------------------
package obef_pkg;

  // direction component width (signed fixed point)
  localparam int DIR_W = 16;
  // number of principal axes
  localparam int NUM_AXES = 3;
  // configuration register width
  localparam int CFG_W = 48;
  // rank code width
  localparam int RANK_W = 2;

  // parameter defaults
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int DIR_FRAC_BITS_DEF = 14;

  // control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic last_pt;
  } obef_ctl_t;

endpackage

[design/oriented_box_extent_finder_unit.sv]
`timescale 1ns / 1ps
// A final point moves through the input, projection, extremes and center registers into
// the result buffer. Throughput: one point per cycle while no final point is held; a final
// point yields three result beats on consecutive cycles while out_tready is high.
// The three-entry result buffer sets the pace: a final point waits at the center stage
// until the previous results are drained, which stalls the whole pipeline.
// Reset (synchronous, rst_n low) clears pipeline valids, the open-cloud flag and registers.
// ----------------------------------------------------------------------------
// oriented_box_extent_finder_unit: oriented bounding box extents
// Projects each point onto three configured axes, tracks per-axis min and max,
// and on the last point emits direction and extent per sorted axis, each beat with one box center coordinate.
// ----------------------------------------------------------------------------
module oriented_box_extent_finder_unit
  import obef_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input beats: point_x, point_y, point_z from bit 0 up, zero padded
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  input  logic                                     in_tlast,
  // result beats: axis_rank, dir_x, dir_y, dir_z, extent_length, center_coord
  // from bit 0 up, zero padded; tlast carries run_end
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((2*COORD_WIDTH+56+7)/8)*8-1:0]    out_tdata,
  output logic                                     out_tlast,
  // register port
  input  logic                                     cfg_psel,
  input  logic                                     cfg_penable,
  input  logic                                     cfg_pwrite,
  input  logic [5:0]                               cfg_paddr,
  input  logic [63:0]                              cfg_pwdata,
  output logic [63:0]                              cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int IN_W   = ((3*COORD_WIDTH+7)/8)*8;
  localparam int OUT_W  = ((2*COORD_WIDTH+56+7)/8)*8;
  localparam int PROJ_W = COORD_WIDTH + 2;
  localparam int CTR_W  = COORD_WIDTH + 4;
  localparam int DIRS_W = NUM_AXES * DIR_W;
  localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(NUM_AXES - 1);

  typedef enum logic [2:0] {
    REG_WGT0 = 3'd0,
    REG_WGT1 = 3'd1,
    REG_WGT2 = 3'd2,
    REG_DIR0 = 3'd3,
    REG_DIR1 = 3'd4,
    REG_DIR2 = 3'd5
  } reg_idx_t;

  // configuration
  logic signed [CFG_W-1:0] wgt_r [NUM_AXES];
  logic        [CFG_W-1:0] dir_r [NUM_AXES];
  reg_idx_t                cfg_idx;
  logic                    cfg_wr;

  // pipeline
  logic                          en;
  obef_ctl_t                     s0_ctl_r;
  logic [IN_W-1:0]               s0_data_r;
  obef_ctl_t                     s2_ctl;
  logic signed [PROJ_W-1:0]      proj [NUM_AXES];
  obef_ctl_t                     s3_ctl_r;
  obef_ctl_t                     s4_ctl;
  logic signed [CTR_W-1:0]       center [NUM_AXES];

  // extremes and cloud state
  logic signed [PROJ_W-1:0]      low_r    [NUM_AXES];
  logic signed [PROJ_W-1:0]      high_r   [NUM_AXES];
  logic signed [PROJ_W-1:0]      low_nxt  [NUM_AXES];
  logic signed [PROJ_W-1:0]      high_nxt [NUM_AXES];
  logic                          have_point_r;

  // per-axis summary at the end of a cloud
  logic signed [PROJ_W:0]        mid_sum  [NUM_AXES];
  logic signed [PROJ_W-1:0]      mid_r    [NUM_AXES];
  logic        [RANK_W-1:0]      rank_c   [NUM_AXES];
  logic        [RANK_W-1:0]      order_c  [NUM_AXES];
  logic        [DIRS_W-1:0]      dir_rank_r [NUM_AXES];
  logic        [PROJ_W-1:0]      ext_rank_r [NUM_AXES];
  logic        [DIRS_W-1:0]      s4_dir_r   [NUM_AXES];
  logic        [PROJ_W-1:0]      s4_ext_r   [NUM_AXES];

  // result buffer
  logic        [DIRS_W-1:0]      buf_dir_r [NUM_AXES];
  logic        [PROJ_W-1:0]      buf_ext_r [NUM_AXES];
  logic signed [CTR_W-1:0]       buf_ctr_r [NUM_AXES];
  logic                          out_busy_r;
  logic        [RANK_W-1:0]      out_rank_r;
  logic                          buf_free;

  // ---------------------------------------------------------------- register port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        wgt_r[a] <= '0;
        dir_r[a] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WGT0: wgt_r[0] <= cfg_pwdata[CFG_W-1:0];
        REG_WGT1: wgt_r[1] <= cfg_pwdata[CFG_W-1:0];
        REG_WGT2: wgt_r[2] <= cfg_pwdata[CFG_W-1:0];
        REG_DIR0: dir_r[0] <= cfg_pwdata[CFG_W-1:0];
        REG_DIR1: dir_r[1] <= cfg_pwdata[CFG_W-1:0];
        REG_DIR2: dir_r[2] <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_WGT0: cfg_prdata = 64'(unsigned'(wgt_r[0]));
      REG_WGT1: cfg_prdata = 64'(unsigned'(wgt_r[1]));
      REG_WGT2: cfg_prdata = 64'(unsigned'(wgt_r[2]));
      REG_DIR0: cfg_prdata = 64'(dir_r[0]);
      REG_DIR1: cfg_prdata = 64'(dir_r[1]);
      REG_DIR2: cfg_prdata = 64'(dir_r[2]);
      default:  cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // a final point may enter the buffer only once the previous results are gone
  assign buf_free  = !out_busy_r || (out_tready && out_rank_r == RANK_LAST);
  assign en        = !(s4_ctl.valid && s4_ctl.last_pt && !buf_free);
  assign in_tready = en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r <= '0;
    end else if (en) begin
      s0_ctl_r.valid   <= in_tvalid;
      s0_ctl_r.last_pt <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_data_r <= in_tdata;
    end
  end

  // ---------------------------------------------------------------- projection
  obef_proj #(
    .COORD_WIDTH   (COORD_WIDTH),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_proj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (s0_ctl_r),
    .pt_x    (s0_data_r[COORD_WIDTH-1:0]),
    .pt_y    (s0_data_r[2*COORD_WIDTH-1:COORD_WIDTH]),
    .pt_z    (s0_data_r[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .dir_cfg (dir_r),
    .ctl_out (s2_ctl),
    .proj    (proj)
  );

  // ---------------------------------------------------------------- extremes
  // a point that opens a cloud overwrites both extremes
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      low_nxt[a]  = low_r[a];
      high_nxt[a] = high_r[a];
      if (s2_ctl.valid) begin
        if (!have_point_r || proj[a] < low_r[a]) begin
          low_nxt[a] = proj[a];
        end
        if (!have_point_r || proj[a] > high_r[a]) begin
          high_nxt[a] = proj[a];
        end
      end
      mid_sum[a] = {low_nxt[a][PROJ_W-1], low_nxt[a]} + {high_nxt[a][PROJ_W-1], high_nxt[a]};
    end
  end

  // stable rank by weight: ties go to the lower axis number
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      rank_c[a] = '0;
      for (int b = 0; b < NUM_AXES; b++) begin
        if (b != a) begin
          if (wgt_r[b] > wgt_r[a] || (wgt_r[b] == wgt_r[a] && b < a)) begin
            rank_c[a] = rank_c[a] + RANK_W'(1);
          end
        end
      end
    end
    for (int r = 0; r < NUM_AXES; r++) begin
      order_c[r] = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (rank_c[a] == RANK_W'(r)) begin
          order_c[r] = RANK_W'(a);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r     <= '0;
      have_point_r <= 1'b0;
    end else if (en) begin
      s3_ctl_r <= s2_ctl;
      if (s2_ctl.valid) begin
        have_point_r <= !s2_ctl.last_pt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        low_r[a]      <= low_nxt[a];
        high_r[a]     <= high_nxt[a];
        mid_r[a]      <= mid_sum[a][PROJ_W:1];
        dir_rank_r[a] <= dir_r[order_c[a]];
        ext_rank_r[a] <= high_nxt[order_c[a]] - low_nxt[order_c[a]];
      end
    end
  end

  // ---------------------------------------------------------------- center
  obef_center #(
    .COORD_WIDTH   (COORD_WIDTH),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_center (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (s3_ctl_r),
    .mid     (mid_r),
    .dir_cfg (dir_r),
    .ctl_out (s4_ctl),
    .center  (center)
  );

  // sorted direction and extent ride alongside the center products
  always_ff @(posedge clk) begin
    if (en) begin
      s4_dir_r <= dir_rank_r;
      s4_ext_r <= ext_rank_r;
    end
  end

  // ---------------------------------------------------------------- result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_busy_r <= 1'b0;
      out_rank_r <= '0;
    end else if (en && s4_ctl.valid && s4_ctl.last_pt) begin
      out_busy_r <= 1'b1;
      out_rank_r <= '0;
    end else if (out_busy_r && out_tready) begin
      if (out_rank_r == RANK_LAST) begin
        out_busy_r <= 1'b0;
        out_rank_r <= '0;
      end else begin
        out_rank_r <= out_rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_ctl.valid && s4_ctl.last_pt) begin
      buf_dir_r <= s4_dir_r;
      buf_ext_r <= s4_ext_r;
      buf_ctr_r <= center;
    end
  end

  // output beat
  assign out_tvalid = out_busy_r;
  assign out_tlast  = (out_rank_r == RANK_LAST);
  assign out_tdata  = OUT_W'({unsigned'(buf_ctr_r[out_rank_r]), buf_ext_r[out_rank_r],
                              buf_dir_r[out_rank_r], out_rank_r});

  // ---------------------------------------------------------------- checks
  // a final point closes the cloud
  a_cloud_closed: assert property (@(posedge clk) disable iff (!rst_n)
    en && s2_ctl.valid && s2_ctl.last_pt |=> !have_point_r)
    else $error("cloud still open after final point");

  // weight ranks form a permutation
  a_rank_perm: assert property (@(posedge clk) disable iff (!rst_n)
    en && s2_ctl.valid && s2_ctl.last_pt |->
      rank_c[0] != rank_c[1] && rank_c[0] != rank_c[2] && rank_c[1] != rank_c[2])
    else $error("axis ranks are not distinct");

  // the buffer drains only after the third beat
  a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_busy_r) |-> $past(out_rank_r) == RANK_LAST && $past(out_tready))
    else $error("result buffer released early");

  // no result set is overwritten before it is sent
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_busy_r && !out_tready |=> out_busy_r && $stable(out_rank_r))
    else $error("pending result lost");

endmodule

[design/obef_proj.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obef_proj: point projection pipeline
// Stage one forms the nine coordinate by component products, stage two sums
// them per axis, floors off the fraction bits and saturates the projection.
// ----------------------------------------------------------------------------
module obef_proj
  import obef_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  obef_ctl_t                     ctl_in,
  input  logic signed [COORD_WIDTH-1:0] pt_x,
  input  logic signed [COORD_WIDTH-1:0] pt_y,
  input  logic signed [COORD_WIDTH-1:0] pt_z,
  input  logic        [CFG_W-1:0]       dir_cfg [NUM_AXES],
  output obef_ctl_t                     ctl_out,
  output logic signed [COORD_WIDTH+1:0] proj [NUM_AXES]
);

  localparam int PROD_W = COORD_WIDTH + DIR_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int PROJ_W = COORD_WIDTH + 2;

  obef_ctl_t                  ctl1_r;
  obef_ctl_t                  ctl2_r;
  logic signed [COORD_WIDTH-1:0] pt_c     [NUM_AXES];
  logic signed [PROD_W-1:0]   prod_nxt [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0]   prod_r   [NUM_AXES][NUM_AXES];
  logic signed [PROJ_W-1:0]   proj_nxt [NUM_AXES];
  logic signed [PROJ_W-1:0]   proj_r   [NUM_AXES];

  assign pt_c[0] = pt_x;
  assign pt_c[1] = pt_y;
  assign pt_c[2] = pt_z;

  // coordinate times direction component, one product per axis and coordinate
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        prod_nxt[a][k] = pt_c[k] * $signed(dir_cfg[a][DIR_W*k +: DIR_W]);
      end
    end
  end

  // dot product, floor shift and saturation per axis
  always_comb begin
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sh;
    logic        [SUM_W-PROJ_W:0] top;
    for (int a = 0; a < NUM_AXES; a++) begin
      sum = {{2{prod_r[a][0][PROD_W-1]}}, prod_r[a][0]}
          + {{2{prod_r[a][1][PROD_W-1]}}, prod_r[a][1]}
          + {{2{prod_r[a][2][PROD_W-1]}}, prod_r[a][2]};
      sh  = sum >>> DIR_FRAC_BITS;
      top = sh[SUM_W-1:PROJ_W-1];
      if ((&top) || !(|top)) begin
        proj_nxt[a] = sh[PROJ_W-1:0];
      end else if (sh[SUM_W-1]) begin
        proj_nxt[a] = {1'b1, {(PROJ_W-1){1'b0}}};
      end else begin
        proj_nxt[a] = {1'b0, {(PROJ_W-1){1'b1}}};
      end
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      proj_r <= proj_nxt;
    end
  end

  assign ctl_out = ctl2_r;
  assign proj    = proj_r;

endmodule

[design/obef_center.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obef_center: box center computation
// Registers the midpoint by component products, then sums each component,
// floors off the fraction bits and saturates the center coordinate.
// ----------------------------------------------------------------------------
module obef_center
  import obef_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  obef_ctl_t                     ctl_in,
  input  logic signed [COORD_WIDTH+1:0] mid [NUM_AXES],
  input  logic        [CFG_W-1:0]       dir_cfg [NUM_AXES],
  output obef_ctl_t                     ctl_out,
  output logic signed [COORD_WIDTH+3:0] center [NUM_AXES]
);

  localparam int PROJ_W = COORD_WIDTH + 2;
  localparam int PROD_W = PROJ_W + DIR_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int CTR_W  = COORD_WIDTH + 4;

  obef_ctl_t                ctl_r;
  logic signed [PROD_W-1:0] prod_nxt [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] prod_r   [NUM_AXES][NUM_AXES];

  // component r of axis a weighted by that axis midpoint
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_nxt[r][a] = mid[a] * $signed(dir_cfg[a][DIR_W*r +: DIR_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // sum, floor shift and saturate per component
  always_comb begin
    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_W-1:0]     sh;
    logic        [SUM_W-CTR_W:0] top;
    for (int r = 0; r < NUM_AXES; r++) begin
      sum = {{2{prod_r[r][0][PROD_W-1]}}, prod_r[r][0]}
          + {{2{prod_r[r][1][PROD_W-1]}}, prod_r[r][1]}
          + {{2{prod_r[r][2][PROD_W-1]}}, prod_r[r][2]};
      sh  = sum >>> DIR_FRAC_BITS;
      top = sh[SUM_W-1:CTR_W-1];
      if ((&top) || !(|top)) begin
        center[r] = sh[CTR_W-1:0];
      end else if (sh[SUM_W-1]) begin
        center[r] = {1'b1, {(CTR_W-1){1'b0}}};
      end else begin
        center[r] = {1'b0, {(CTR_W-1){1'b1}}};
      end
    end
  end

  assign ctl_out = ctl_r;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for oriented_box_extent_finder_unit
// Streams point clouds through the unit, predicts the per-axis extents,
// center and sorted directions of each cloud, and compares every result beat.
// Register settings change between clouds and within an open cloud, sender and receiver idle at random,
// and one long receiver hold-off backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import obef_pkg::*;

  localparam int COORD_W = COORD_WIDTH_DEF;
  localparam int FRAC    = DIR_FRAC_BITS_DEF;
  localparam int PROJ_W  = COORD_W + 2;
  localparam int CTR_W   = COORD_W + 4;
  localparam int IN_W    = ((3 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W   = ((2 * COORD_W + 56 + 7) / 8) * 8;
  // result field offsets in out_tdata
  localparam int DX_LSB  = RANK_W;
  localparam int DY_LSB  = DX_LSB + DIR_W;
  localparam int DZ_LSB  = DY_LSB + DIR_W;
  localparam int EXT_LSB = DZ_LSB + DIR_W;
  localparam int CTR_LSB = EXT_LSB + PROJ_W;

  // register indexes
  localparam int REG_WEIGHT0 = 0;
  localparam int REG_WEIGHT1 = 1;
  localparam int REG_WEIGHT2 = 2;
  localparam int REG_DIR0    = 3;
  localparam int REG_DIR1    = 4;
  localparam int REG_DIR2    = 5;
  localparam int REG_UNUSED6 = 6;
  localparam int REG_UNUSED7 = 7;

  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_POINTS = 60;

  localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [DIR_W-1:0] ONE   = 16'h4000;
  localparam logic [DIR_W-1:0] M_ONE = 16'hC000;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [DIR_W-1:0]  dx;
    logic [DIR_W-1:0]  dy;
    logic [DIR_W-1:0]  dz;
    logic [PROJ_W-1:0] extent;
    logic [CTR_W-1:0]  center;
    logic              last;
  } box_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // point_x, point_y, point_z from bit 0 up
  logic              in_tlast;   // final_point
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // axis_rank, dir_x, dir_y, dir_z, extent_length, center_coord
  logic              out_tlast;  // run_end
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [5:0]        cfg_paddr;
  logic [63:0]       cfg_pwdata;
  logic [63:0]       cfg_prdata;
  logic              cfg_pready;

  oriented_box_extent_finder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // shadow of the unit's registers and cloud state
  logic [CFG_W-1:0] weight_q[NUM_AXES];
  logic [CFG_W-1:0] dir_q[NUM_AXES];
  longint           lo_proj[NUM_AXES];
  longint           hi_proj[NUM_AXES];
  bit               cloud_open;

  box_result_t pending_boxes[$];

  int  errors;
  int  points_sent;
  int  clouds_sent;
  int  beats_seen;
  int  settings_used;
  int  stall_cycles;
  bit  gaps_on;
  bit  idle_on;
  bit  long_hold;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint v, int w);
    longint top;
    top = (longint'(1) <<< (w - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic longint dir_comp(int ax, int k);
    logic [DIR_W-1:0] c;
    c = dir_q[ax][k*DIR_W +: DIR_W];
    return longint'($signed(c));
  endfunction

  // fold one point into the cloud; on the final point queue three box results
  task automatic fold_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                            logic [COORD_W-1:0] pz, bit fin);
    longint      pt[3];
    longint      dot, prj, sum, mid, wa, wb;
    int          ord[3];
    int          a, b, r, rk, ax;
    box_result_t res;
    pt[0] = longint'($signed(px));
    pt[1] = longint'($signed(py));
    pt[2] = longint'($signed(pz));
    for (a = 0; a < NUM_AXES; a++) begin
      dot = pt[0] * dir_comp(a, 0) + pt[1] * dir_comp(a, 1) + pt[2] * dir_comp(a, 2);
      prj = clamp(dot >>> FRAC, PROJ_W);
      if (!cloud_open || prj < lo_proj[a]) lo_proj[a] = prj;
      if (!cloud_open || prj > hi_proj[a]) hi_proj[a] = prj;
    end
    cloud_open = 1'b1;
    if (fin) begin
      // stable descending order of weights
      for (a = 0; a < NUM_AXES; a++) begin
        wa = longint'($signed(weight_q[a]));
        rk = 0;
        for (b = 0; b < NUM_AXES; b++) begin
          wb = longint'($signed(weight_q[b]));
          if (wb > wa || (wb == wa && b < a)) rk++;
        end
        ord[rk] = a;
      end
      for (r = 0; r < NUM_AXES; r++) begin
        ax  = ord[r];
        sum = 0;
        for (a = 0; a < NUM_AXES; a++) begin
          mid = (lo_proj[a] + hi_proj[a]) >>> 1;
          sum += mid * dir_comp(a, r);
        end
        res.rank   = RANK_W'(r);
        res.dx     = dir_q[ax][DIR_W-1:0];
        res.dy     = dir_q[ax][2*DIR_W-1:DIR_W];
        res.dz     = dir_q[ax][3*DIR_W-1:2*DIR_W];
        res.extent = PROJ_W'(hi_proj[ax] - lo_proj[ax]);
        res.center = CTR_W'(clamp(sum >>> FRAC, CTR_W));
        res.last   = (r == NUM_AXES - 1);
        pending_boxes.insert(pending_boxes.size(), res);
      end
      cloud_open = 1'b0;
    end
  endtask

  // one point beat, with an optional gap in front of it
  task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                            logic [COORD_W-1:0] pz, bit fin);
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pz, py, px};
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    fold_point(px, py, pz, fin);
    points_sent++;
    if (fin) clouds_sent++;
  endtask

  // drop valid, wait for all results, then let the pipeline empty out
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup phase, access phase, then an idle phase
  task automatic set_reg(int idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 6'(8 * idx);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    if (idx < NUM_AXES) weight_q[idx] = value[CFG_W-1:0];
    else if (idx < 2 * NUM_AXES) dir_q[idx - NUM_AXES] = value[CFG_W-1:0];
  endtask

  task automatic apply_setting(logic [CFG_W-1:0] w0, logic [CFG_W-1:0] w1,
                               logic [CFG_W-1:0] w2, logic [CFG_W-1:0] d0,
                               logic [CFG_W-1:0] d1, logic [CFG_W-1:0] d2);
    quiesce();
    set_reg(REG_WEIGHT0, 64'(w0));
    set_reg(REG_WEIGHT1, 64'(w1));
    set_reg(REG_WEIGHT2, 64'(w2));
    set_reg(REG_DIR0, 64'(d0));
    set_reg(REG_DIR1, 64'(d1));
    set_reg(REG_DIR2, 64'(d2));
    settings_used++;
  endtask

  function automatic logic [CFG_W-1:0] pack_dir(logic [DIR_W-1:0] cx, logic [DIR_W-1:0] cy,
                                                logic [DIR_W-1:0] cz);
    return {cz, cy, cx};
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return C_MAX;
      1: return C_MIN;
      2: return COORD_W'(int'($urandom_range(0, 200)) - 100);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // mostly near-unit components, some raw 16-bit values
  function automatic logic [DIR_W-1:0] rand_comp();
    if ($urandom_range(0, 3) == 0) return DIR_W'($urandom);
    return DIR_W'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [CFG_W-1:0] rand_weight();
    case ($urandom_range(0, 4))
      0: return {1'b0, {(CFG_W-1){1'b1}}};
      1: return {1'b1, {(CFG_W-1){1'b0}}};
      2: return CFG_W'(int'($urandom_range(0, 4)) - 2);
      default: return CFG_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : box_checker
    box_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (pending_boxes.size() == 0) begin
        $error("result beat with no box result pending");
        errors++;
      end else begin
        want = pending_boxes.pop_front();
        check_field("axis_rank", want.rank, out_tdata[RANK_W-1:0]);
        check_field("dir_x", want.dx, out_tdata[DX_LSB +: DIR_W]);
        check_field("dir_y", want.dy, out_tdata[DY_LSB +: DIR_W]);
        check_field("dir_z", want.dz, out_tdata[DZ_LSB +: DIR_W]);
        check_field("extent_length", want.extent, out_tdata[EXT_LSB +: PROJ_W]);
        check_field("center_coord", want.center, out_tdata[CTR_LSB +: CTR_W]);
        check_field("run_end", want.last, out_tlast);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : sink
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // reset values: zero directions and tied weights
  task automatic test_reset_state();
    send_point(C_MAX, C_MIN, 24'h000123, 1'b1);
  endtask

  // unit axes, single point cloud and coordinate extremes
  task automatic test_unit_axes();
    apply_setting(48'd3, 48'd2, 48'd1, pack_dir(ONE, 16'h0, 16'h0),
                  pack_dir(16'h0, ONE, 16'h0), pack_dir(16'h0, 16'h0, ONE));
    send_point(24'h000005, 24'hFFFFF9, 24'h000000, 1'b1);
    send_point(C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(24'h000000, 24'h000000, 24'h000000, 1'b1);
    send_point(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 1'b0);
    send_point(24'h000003, 24'hFFFFFE, 24'h000007, 1'b1);
  endtask

  // directions near the Q1.14 limits drive projection and center saturation
  task automatic test_saturation();
    apply_setting(48'd1, 48'd2, 48'd3, pack_dir(16'h8000, 16'h8000, 16'h8000),
                  pack_dir(16'h7FFF, 16'h7FFF, 16'h7FFF), pack_dir(16'h8000, 16'h7FFF, M_ONE));
    send_point(C_MIN, C_MIN, C_MIN, 1'b1);
    send_point(C_MAX, C_MAX, C_MAX, 1'b1);
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MAX, C_MAX, 1'b1);
  endtask

  // weight extremes and ties, plus writes to addresses past the last register
  task automatic test_weight_order();
    logic [CFG_W-1:0] wmax, wmin;
    logic [CFG_W-1:0] d0, d1, d2;
    wmax = {1'b0, {(CFG_W-1){1'b1}}};
    wmin = {1'b1, {(CFG_W-1){1'b0}}};
    d0 = pack_dir(16'h2D41, 16'h2D41, 16'h0000);
    d1 = pack_dir(16'hD2BF, 16'h2D41, 16'h0000);
    d2 = pack_dir(16'h0000, 16'h0000, M_ONE);
    apply_setting(wmin, wmax, 48'd0, d0, d1, d2);
    send_point(24'h001000, 24'hFFF000, 24'h000800, 1'b0);
    send_point(24'hFFE000, 24'h003000, 24'hFFF800, 1'b1);
    apply_setting(48'd7, 48'd7, 48'd7, d0, d1, d2);
    set_reg(REG_UNUSED6, {$urandom, $urandom});
    set_reg(REG_UNUSED7, {$urandom, $urandom});
    send_point(24'h000400, 24'h000100, 24'hFFFF00, 1'b1);
    apply_setting(wmin, wmin, wmax, d0, d1, d2);
    send_point(C_MAX, 24'h000000, C_MIN, 1'b1);
    apply_setting(48'hFFFFFFFFFFFF, wmax, wmax, d0, d1, d2);
    send_point(24'h012345, 24'hFEDCBA, 24'h000042, 1'b1);
  endtask

  // directions and weights rewritten while a cloud is open
  task automatic test_midcloud_write();
    send_point(24'h000100, 24'h000200, 24'h000300, 1'b0);
    send_point(24'hFFFF00, 24'h000050, 24'hFFFFA0, 1'b0);
    apply_setting(48'd5, 48'd9, 48'hFFFFFFFFFFFE, pack_dir(16'h0000, ONE, 16'h0000),
                  pack_dir(M_ONE, 16'h0000, 16'h0000), pack_dir(16'h1000, 16'h2000, 16'h3000));
    send_point(24'h000777, 24'hFFF111, 24'h000020, 1'b1);
  endtask

  // random clouds under random settings, mostly short
  task automatic test_random_clouds(int count);
    int target, len, k;
    target = points_sent + count;
    while (points_sent < target) begin
      if ($urandom_range(0, 2) == 0)
        apply_setting(rand_weight(), rand_weight(), rand_weight(),
                      pack_dir(rand_comp(), rand_comp(), rand_comp()),
                      pack_dir(rand_comp(), rand_comp(), rand_comp()),
                      pack_dir(rand_comp(), rand_comp(), rand_comp()));
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
      for (k = 0; k < len; k++)
        send_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
    end
  endtask

  // receiver holds off while the sender keeps offering clouds
  task automatic test_backpressure();
    int c;
    quiesce();
    gaps_on   = 1'b0;
    long_hold = 1'b1;
    for (c = 0; c < 12; c++) begin
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
    end
    gaps_on = 1'b1;
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    int k;
    quiesce();
    gaps_on = 1'b0;
    idle_on = 1'b0;
    for (k = 0; k < 24; k++)
      send_point(rand_coord(), rand_coord(), rand_coord(), (k % 3) == 2);
  endtask

  initial begin : main
    int a;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    errors        = 0;
    points_sent   = 0;
    clouds_sent   = 0;
    beats_seen    = 0;
    settings_used = 0;
    stall_cycles  = 0;
    gaps_on       = 1'b1;
    idle_on       = 1'b1;
    long_hold     = 1'b0;
    cloud_open    = 1'b0;
    for (a = 0; a < NUM_AXES; a++) begin
      weight_q[a] = '0;
      dir_q[a]    = '0;
      lo_proj[a]  = 0;
      hi_proj[a]  = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_unit_axes();
    test_saturation();
    test_weight_order();
    test_midcloud_write();
    test_random_clouds(RANDOM_POINTS);
    test_backpressure();
    test_full_rate();
    quiesce();

    $display("covered %0d points in %0d clouds, %0d result beats, %0d register settings",
             points_sent, clouds_sent, beats_seen, settings_used);
    $display("including saturation, weight ties and extremes, mid-cloud writes, long stall");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/obef_pkg.sv
design/obef_proj.sv
design/obef_center.sv
design/oriented_box_extent_finder_unit.sv
verif/testbench.sv
